FILE: hdl/sjc_pkg.sv
// Shared types, codes and helper functions of the splice junction counter.
// No dependencies; imported by every module of the block.
package sjc_pkg;

    localparam int KEY_W = 84;   // {chrom, start, stop, orient}

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_OP     = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [2:0] ST_READ_OK     = 3'd0;
    localparam logic [2:0] ST_READ_FILT   = 3'd1;
    localparam logic [2:0] ST_NO_JUNC     = 3'd2;
    localparam logic [2:0] ST_INSERTED    = 3'd3;
    localparam logic [2:0] ST_COUNTED     = 3'd4;
    localparam logic [2:0] ST_FULL_DROP   = 3'd5;
    localparam logic [2:0] ST_ENTRY_VALID = 3'd6;
    localparam logic [2:0] ST_ENTRY_EMPTY = 3'd7;

    localparam logic [3:0] OP_M  = 4'd0;
    localparam logic [3:0] OP_D  = 4'd2;
    localparam logic [3:0] OP_N  = 4'd3;
    localparam logic [3:0] OP_EQ = 4'd7;
    localparam logic [3:0] OP_X  = 4'd8;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_PASS,
        CMD_JUNC,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [2:0]  status;
        logic [15:0] chrom;
        logic [31:0] start;
        logic [31:0] stop;
        logic [3:0]  orient;
        logic [7:0]  idx;
    } sjc_cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CMP,
        B_UPD
    } back_state_t;

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? MAX32 : s[31:0];
    endfunction

    function automatic logic [3:0] pair_code(input logic [11:0] flags,
                                             input logic        same_chrom,
                                             input logic        first);
        logic r1, rev, mrev;
        logic [3:0] code;
        r1   = flags[6];
        rev  = flags[4];
        mrev = flags[5];
        if (!(flags[6] || flags[7]) || !same_chrom) begin
            code = 4'd0;
        end else if (r1) begin
            if (first) code = rev ? (mrev ? 4'd5 : 4'd7) : (mrev ? 4'd1 : 4'd3);
            else       code = rev ? (mrev ? 4'd6 : 4'd2) : (mrev ? 4'd8 : 4'd4);
        end else begin
            if (first) code = rev ? (mrev ? 4'd6 : 4'd8) : (mrev ? 4'd2 : 4'd4);
            else       code = rev ? (mrev ? 4'd5 : 4'd1) : (mrev ? 4'd7 : 4'd3);
        end
        return code;
    endfunction

endpackage

FILE: hdl/sjc_front.sv
// Front end: config register, read filtering, orientation and cursor tracking.
// Turns each input transaction into one command for the back end. Uses sjc_pkg.
module sjc_front
    import sjc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        accept,
    input  logic [1:0]  kind,
    input  logic [11:0] flags,
    input  logic [15:0] chrom,
    input  logic [15:0] mate_chrom,
    input  logic [31:0] position,
    input  logic [31:0] mate_position,
    input  logic [7:0]  map_quality,
    input  logic [3:0]  op_code,
    input  logic [27:0] op_length,
    input  logic [7:0]  entry_index,
    output sjc_cmd_t    cmd
);

    logic [7:0]  min_q_reg;
    logic        active_reg, active_next;
    logic [31:0] cursor_reg, cursor_next;
    logic [15:0] rchrom_reg, rchrom_next;
    logic [3:0]  rorient_reg, rorient_next;

    logic        consumes;
    logic [31:0] after;
    logic [31:0] hdr_cursor;
    logic [3:0]  hdr_orient;

    always_comb
    begin
        consumes   = (op_code == OP_M) || (op_code == OP_D) || (op_code == OP_N) ||
                     (op_code == OP_EQ) || (op_code == OP_X);
        after      = consumes ? add_sat(cursor_reg, {4'd0, op_length}) : cursor_reg;
        hdr_cursor = add_sat(position, 32'd1);
        hdr_orient = pair_code(flags, chrom == mate_chrom, position < mate_position);

        active_next  = active_reg;
        cursor_next  = cursor_reg;
        rchrom_next  = rchrom_reg;
        rorient_next = rorient_reg;

        cmd        = '0;
        cmd.kind   = CMD_PASS;
        cmd.status = ST_ENTRY_EMPTY;
        cmd.idx    = entry_index;

        case (kind)
            KIND_HEADER:
            begin
                if (map_quality < min_q_reg || flags[8]) begin
                    active_next = 1'b0;
                    cmd.status  = ST_READ_FILT;
                end else begin
                    active_next  = 1'b1;
                    cursor_next  = hdr_cursor;
                    rchrom_next  = chrom;
                    rorient_next = hdr_orient;
                    cmd.status   = ST_READ_OK;
                    cmd.chrom    = chrom;
                    cmd.start    = hdr_cursor;
                    cmd.orient   = hdr_orient;
                end
            end
            KIND_OP:
            begin
                cmd.status = ST_NO_JUNC;
                if (active_reg) begin
                    cursor_next = after;
                    if (op_code == OP_N) begin
                        cmd.kind   = CMD_JUNC;
                        cmd.chrom  = rchrom_reg;
                        cmd.start  = cursor_reg;
                        cmd.stop   = after;
                        cmd.orient = rorient_reg;
                    end
                end
            end
            KIND_READ:
            begin
                cmd.kind = CMD_READ;
            end
            default:
            begin
                cmd.status = ST_ENTRY_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            min_q_reg   <= 8'd20;
            active_reg  <= 1'b0;
            cursor_reg  <= '0;
            rchrom_reg  <= '0;
            rorient_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                min_q_reg <= cfg_wr_data;
            end
            if (accept) begin
                active_reg  <= active_next;
                cursor_reg  <= cursor_next;
                rchrom_reg  <= rchrom_next;
                rorient_reg <= rorient_next;
            end
        end
    end

endmodule

FILE: hdl/sjc_fifo.sv
// Two-entry command queue between the front end and the table back end.
// Uses sjc_pkg for the command type.
module sjc_fifo
    import sjc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  sjc_cmd_t wdata,
    input  logic     pop,
    output sjc_cmd_t rdata,
    output logic     full,
    output logic     empty
);

    sjc_cmd_t   mem [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: hdl/sjc_table.sv
// Back end: sorted junction table as a shifting cell chain plus output register.
// Compare cycle flags every cell, update cycle counts, shifts or drops. Uses sjc_pkg.
module sjc_table
    import sjc_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_avail,
    input  sjc_cmd_t     cmd,
    output logic         cmd_pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [2:0]   out_status,
    output logic [124:0] out_data
);

    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

    logic [KEY_W-1:0] cell_key_reg [TABLE_DEPTH];
    logic [31:0]      cell_cnt_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] ge_reg, ge_next;
    logic [TABLE_DEPTH-1:0] eq_reg, eq_next;
    logic [FILL_W-1:0] fill_reg;
    back_state_t      state_reg, state_next;
    sjc_cmd_t         jcmd_reg;
    logic [KEY_W-1:0] key;

    logic         oval_reg;
    logic [2:0]   ost_reg;
    logic [15:0]  ochrom_reg;
    logic [31:0]  ostart_reg, ostop_reg, ocnt_reg;
    logic [3:0]   oorient_reg;
    logic [31:0]  fill32;

    logic         out_free;
    logic         any_eq;
    logic         full;
    logic [31:0]  match_cnt;
    logic [KEY_W-1:0] rd_key;
    logic [31:0]  rd_cnt;
    logic         rd_hit;

    assign key      = {jcmd_reg.chrom, jcmd_reg.start, jcmd_reg.stop, jcmd_reg.orient};
    assign out_free = !oval_reg || out_ready;
    assign any_eq   = |eq_reg;
    assign fill32   = 32'(fill_reg);
    assign full     = (fill32 >= 32'(TABLE_DEPTH));
    assign rd_hit   = 32'(cmd.idx) < fill32;

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            ge_next[i] = (32'(i) < fill32) && (cell_key_reg[i] >= key);
            eq_next[i] = (32'(i) < fill32) && (cell_key_reg[i] == key);
        end
    end

    // Sorted table: at most one cell can match, so an OR picks its count.
    always_comb
    begin
        match_cnt = '0;
        rd_key    = '0;
        rd_cnt    = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (eq_reg[i]) match_cnt = match_cnt | cell_cnt_reg[i];
            if (32'(i) == 32'(cmd.idx)) begin
                rd_key = cell_key_reg[i];
                rd_cnt = cell_cnt_reg[i];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_avail && out_free) begin
                    cmd_pop = 1'b1;
                    if (cmd.kind == CMD_JUNC) state_next = B_CMP;
                end
            end
            B_CMP:   state_next = B_UPD;
            B_UPD:   state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= B_IDLE;
            fill_reg  <= '0;
            oval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_ready) oval_reg <= 1'b0;
            if (cmd_pop && cmd.kind != CMD_JUNC) oval_reg <= 1'b1;
            if (state_reg == B_UPD) begin
                oval_reg <= 1'b1;
                if (!any_eq && !full) fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop) begin
            jcmd_reg    <= cmd;
            ost_reg     <= cmd.status;
            ochrom_reg  <= cmd.chrom;
            ostart_reg  <= cmd.start;
            ostop_reg   <= cmd.stop;
            oorient_reg <= cmd.orient;
            ocnt_reg    <= '0;
            if (cmd.kind == CMD_READ) begin
                if (rd_hit) begin
                    ost_reg     <= ST_ENTRY_VALID;
                    ochrom_reg  <= rd_key[83:68];
                    ostart_reg  <= rd_key[67:36];
                    ostop_reg   <= rd_key[35:4];
                    oorient_reg <= rd_key[3:0];
                    ocnt_reg    <= rd_cnt;
                end else begin
                    ost_reg     <= ST_ENTRY_EMPTY;
                    ochrom_reg  <= '0;
                    ostart_reg  <= '0;
                    ostop_reg   <= '0;
                    oorient_reg <= '0;
                end
            end
        end
        if (state_reg == B_CMP) begin
            ge_reg <= ge_next;
            eq_reg <= eq_next;
        end
        if (state_reg == B_UPD) begin
            if (any_eq) begin
                ost_reg  <= ST_COUNTED;
                ocnt_reg <= add_sat(match_cnt, 32'd1);
            end else if (full) begin
                ost_reg <= ST_FULL_DROP;
            end else begin
                ost_reg  <= ST_INSERTED;
                ocnt_reg <= 32'd1;
            end
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (any_eq) begin
                    if (eq_reg[i]) cell_cnt_reg[i] <= add_sat(cell_cnt_reg[i], 32'd1);
                end else if (!full) begin
                    if (i > 0 && ge_reg[(i > 0) ? i - 1 : 0]) begin
                        cell_key_reg[i] <= cell_key_reg[(i > 0) ? i - 1 : 0];
                        cell_cnt_reg[i] <= cell_cnt_reg[(i > 0) ? i - 1 : 0];
                    end else if (ge_reg[i] || 32'(i) == fill32) begin
                        cell_key_reg[i] <= key;
                        cell_cnt_reg[i] <= 32'd1;
                    end
                end
            end
        end
    end

    assign out_valid  = oval_reg;
    assign out_status = ost_reg;
    assign out_data   = {fill32[8:0], ocnt_reg, oorient_reg, ostop_reg, ostart_reg, ochrom_reg};

endmodule

FILE: hdl/splice_junction_counter_core.sv
// Top level of the splice junction counter: input stream, command queue, table.
// Depends on sjc_pkg, sjc_front, sjc_fifo and sjc_table.
//
// Usage:
//   s_axis carries one transaction per item: tuser = kind (0 read header,
//   1 cigar op, 2 table read), tdata = the packed header/op/index fields.
//   m_axis returns exactly one transaction per input item, in order:
//   tuser = status code, tdata = junction or entry fields and entries used.
//   cfg_wr_en/cfg_wr_data write the minimum mapping quality (reset 20);
//   write it only while the block is idle.
// Timing:
//   The front end classifies an item in the accept cycle and queues a
//   command (two-entry queue); the back end pops it when idle with the output
//   register free. Headers, ops and table reads go from the queue straight
//   into the output register; a skip op (junction) first passes a compare
//   state over all table cells and an update state (count, shift-insert or
//   drop), and the back end takes no new command until it is through them.
// Reset:
//   Clears the fill level, read state and queue; table cells hold garbage
//   that is never visible since reads beyond the fill level answer empty.
// Stall:
//   When m_axis_tready is low the output register holds, the back end waits,
//   the queue fills and s_axis_tready drops once two commands wait.
module splice_junction_counter_core
    import sjc_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [11:0] flags, [27:12] chrom, [43:28] mate_chrom, [75:44] position,
    // [107:76] mate_position, [115:108] map_quality, [119:116] op_code,
    // [147:120] op_length, [155:148] entry_index, [159:156] zero
    input  logic [159:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,   // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] out_chrom, [47:16] out_start, [79:48] out_end,
    // [83:80] out_orientation, [115:84] out_count, [124:116] entries_used,
    // [127:125] zero
    output logic [127:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser    // status
);

    sjc_cmd_t     front_cmd;
    sjc_cmd_t     back_cmd;
    logic         q_full;
    logic         q_empty;
    logic         q_pop;
    logic         accept;
    logic [124:0] out_data;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    sjc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .accept        (accept),
        .kind          (s_axis_tuser),
        .flags         (s_axis_tdata[11:0]),
        .chrom         (s_axis_tdata[27:12]),
        .mate_chrom    (s_axis_tdata[43:28]),
        .position      (s_axis_tdata[75:44]),
        .mate_position (s_axis_tdata[107:76]),
        .map_quality   (s_axis_tdata[115:108]),
        .op_code       (s_axis_tdata[119:116]),
        .op_length     (s_axis_tdata[147:120]),
        .entry_index   (s_axis_tdata[155:148]),
        .cmd           (front_cmd)
    );

    sjc_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (front_cmd),
        .pop   (q_pop),
        .rdata (back_cmd),
        .full  (q_full),
        .empty (q_empty)
    );

    sjc_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_avail  (!q_empty),
        .cmd        (back_cmd),
        .cmd_pop    (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_data   (out_data)
    );

    assign m_axis_tdata = {3'b000, out_data};

endmodule
